// ===== rtl/pwm_period_duty_capture_core_macros.svh =====
// assertion macros for the pwm period and duty capture core
`ifndef PWM_PERIOD_DUTY_CAPTURE_CORE_MACROS_SVH
`define PWM_PERIOD_DUTY_CAPTURE_CORE_MACROS_SVH

// property that must hold at every clock outside reset
`define PDC_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("pdc assertion failed");

// same-cycle implication outside reset
`define PDC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pdc implication failed");

`endif

// ===== rtl/pdc_pkg.sv =====
// shared types, constants and helper functions for the pwm capture core
package pdc_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PRESCALE_SELECT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CLOCK_HZ        = 2'd1;

   localparam logic [2:0]  PRESCALE_SELECT_RESET = 3'd1;
   localparam logic [31:0] CLOCK_HZ_RESET        = 32'd8000000;

   localparam logic [2:0] SEL_DIV1    = 3'd1;
   localparam logic [2:0] SEL_DIV8    = 3'd2;
   localparam logic [2:0] SEL_DIV64   = 3'd3;
   localparam logic [2:0] SEL_DIV256  = 3'd4;
   localparam logic [2:0] SEL_DIV1024 = 3'd5;

   localparam logic [6:0] DUTY_MAX = 7'd100;

   typedef struct packed {
      logic [2:0]  prescale_select;
      logic [31:0] clock_hz;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } fifo_status_type;

   // prescale factor, zero when the timer is stopped
   function automatic logic [10:0] prescale_factor(input logic [2:0] sel);
      logic [10:0] f;
      unique case (sel)
         SEL_DIV1:    f = 11'd1;
         SEL_DIV8:    f = 11'd8;
         SEL_DIV64:   f = 11'd64;
         SEL_DIV256:  f = 11'd256;
         SEL_DIV1024: f = 11'd1024;
         default:     f = 11'd0;
      endcase
      return f;
   endfunction

   // log2 of the prescale factor
   function automatic logic [3:0] prescale_shift(input logic [2:0] sel);
      logic [3:0] s;
      unique case (sel)
         SEL_DIV8:    s = 4'd3;
         SEL_DIV64:   s = 4'd6;
         SEL_DIV256:  s = 4'd8;
         SEL_DIV1024: s = 4'd10;
         default:     s = 4'd0;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/pdc_front.sv =====
// edge detection, prescaler and tick counting; hands finished measurements on
module pdc_front #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pdc_pkg::cfg_type       cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic                   in_level,
   input  logic                   queue_full,
   output logic                   push,
   output logic [COUNT_WIDTH-1:0] push_tick,
   output logic [COUNT_WIDTH-1:0] push_high,
   output logic                   push_sat
);

   typedef enum logic [2:0] {
      PH_WAIT = 3'b001,
      PH_HIGH = 3'b010,
      PH_LOW  = 3'b100
   } phase_type;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   phase_type              phase_ff, phase_in;
   logic                   last_ff, last_in;
   logic [9:0]             presc_ff, presc_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [COUNT_WIDTH-1:0] high_ff, high_in;
   logic                   sat_ff, sat_in;

   logic        accept;
   logic        rise;
   logic        fall;
   logic [10:0] factor;
   logic        active;
   logic        counting;

   assign in_ready = ~queue_full;
   assign accept   = in_valid & ~queue_full;
   assign factor   = pdc_pkg::prescale_factor(cfg.prescale_select);
   assign active   = (factor != 11'd0);
   assign rise     = in_level & ~last_ff;
   assign fall     = ~in_level & last_ff;
   assign counting = ((phase_ff == PH_HIGH) || (phase_ff == PH_LOW)) && active;

   always_comb begin
      phase_in  = phase_ff;
      last_in   = last_ff;
      presc_in  = presc_ff;
      tick_in   = tick_ff;
      high_in   = high_ff;
      sat_in    = sat_ff;
      push      = 1'b0;
      push_tick = tick_ff;
      push_high = high_ff;
      push_sat  = sat_ff;
      if (accept) begin
         last_in = in_level;
         if (counting) begin
            if ((11'(presc_ff) + 11'd1) >= factor) begin
               presc_in = '0;
               if (tick_ff != COUNT_MAX) begin
                  tick_in = tick_ff + 1'b1;
               end
               if (tick_in == COUNT_MAX) begin
                  sat_in = 1'b1;
               end
            end else begin
               presc_in = presc_ff + 10'd1;
            end
         end
         push_tick = tick_in;
         push_sat  = sat_in;
         if ((phase_ff == PH_HIGH) && fall) begin
            high_in  = tick_in;
            phase_in = PH_LOW;
         end else if (rise) begin
            push     = (phase_ff == PH_LOW) && active;
            tick_in  = '0;
            high_in  = '0;
            presc_in = '0;
            sat_in   = 1'b0;
            phase_in = PH_HIGH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         last_ff  <= 1'b1;
         presc_ff <= '0;
         tick_ff  <= '0;
         high_ff  <= '0;
         sat_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         last_ff  <= last_in;
         presc_ff <= presc_in;
         tick_ff  <= tick_in;
         high_ff  <= high_in;
         sat_ff   <= sat_in;
      end
   end

endmodule

// ===== rtl/pdc_fifo.sv =====
// two-entry queue between the capture front and the arithmetic back
module pdc_fifo #(
   parameter int DATA_WIDTH = 65
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [DATA_WIDTH-1:0]   push_data,
   input  logic                    pop,
   output logic [DATA_WIDTH-1:0]   pop_data,
   output pdc_pkg::fifo_status_type status
);

   localparam int DEPTH   = 2;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign status.full      = (count_ff == COUNT_W'(DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign do_push  = push & ~status.full;
   assign do_pop   = pop & status.not_empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/pdc_back.sv =====
// clamping, duty and frequency division on a shared radix-2 divider, result register
module pdc_back #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pdc_pkg::cfg_type       cfg,
   input  logic                   job_valid,
   output logic                   job_pop,
   input  logic [COUNT_WIDTH-1:0] job_tick,
   input  logic [COUNT_WIDTH-1:0] job_high,
   input  logic                   job_sat,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [31:0]            out_period_ticks,
   output logic [31:0]            out_high_ticks,
   output logic [6:0]             out_duty_percent,
   output logic [31:0]            out_frequency_hz,
   output logic                   out_count_saturated
);

   localparam int DUTY_W = COUNT_WIDTH + 7;
   localparam int FREQ_W = 32;
   localparam int DW     = (COUNT_WIDTH + 10 > FREQ_W) ? COUNT_WIDTH + 10 : FREQ_W;
   localparam int ITER_W = $clog2(((DUTY_W > FREQ_W) ? DUTY_W : FREQ_W) + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DUTY  = 4'b0010,
      ST_FREQ  = 4'b0100,
      ST_STORE = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [DW:0]        rem_ff, rem_in;
   logic [DW-1:0]      num_ff, num_in;
   logic [DW-1:0]      quo_ff, quo_in;
   logic [DW-1:0]      div_ff, div_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic               zero_ff, zero_in;
   logic [31:0]        per_ff, per_in;
   logic [31:0]        hi_ff, hi_in;
   logic               sat_ff, sat_in;
   logic [6:0]         duty_ff, duty_in;
   logic [31:0]        freq_ff, freq_in;

   logic               out_valid_ff, out_valid_in;
   logic [31:0]        out_per_ff, out_per_in;
   logic [31:0]        out_hi_ff, out_hi_in;
   logic [6:0]         out_duty_ff, out_duty_in;
   logic [31:0]        out_freq_ff, out_freq_in;
   logic               out_sat_ff, out_sat_in;

   logic [DW:0]        rem_sh;
   logic               take;
   logic [DW:0]        step_rem;
   logic [DW-1:0]      step_quo;
   logic [63:0]        tick_wide;
   logic [63:0]        high_wide;
   logic [DUTY_W-1:0]  high_x100;

   assign rem_sh    = {rem_ff[DW-1:0], num_ff[DW-1]};
   assign take      = (rem_sh >= {1'b0, div_ff});
   assign step_rem  = take ? (rem_sh - {1'b0, div_ff}) : rem_sh;
   assign step_quo  = {quo_ff[DW-2:0], take};
   assign tick_wide = 64'(job_tick);
   assign high_wide = 64'(job_high);
   assign high_x100 = (DUTY_W'(job_high) << 6) + (DUTY_W'(job_high) << 5)
                    + (DUTY_W'(job_high) << 2);

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      div_in       = div_ff;
      iter_in      = iter_ff;
      tick_in      = tick_ff;
      zero_in      = zero_ff;
      per_in       = per_ff;
      hi_in        = hi_ff;
      sat_in       = sat_ff;
      duty_in      = duty_ff;
      freq_in      = freq_ff;
      out_valid_in = out_valid_ff & ~out_ready;
      out_per_in   = out_per_ff;
      out_hi_in    = out_hi_ff;
      out_duty_in  = out_duty_ff;
      out_freq_in  = out_freq_ff;
      out_sat_in   = out_sat_ff;
      job_pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               sat_in  = job_sat;
               if (tick_wide[63:32] != 32'd0) begin
                  per_in = '1;
                  sat_in = 1'b1;
               end else begin
                  per_in = tick_wide[31:0];
               end
               if (high_wide[63:32] != 32'd0) begin
                  hi_in  = '1;
                  sat_in = 1'b1;
               end else begin
                  hi_in = high_wide[31:0];
               end
               tick_in  = job_tick;
               zero_in  = (job_tick == '0);
               num_in   = DW'(high_x100) << (DW - DUTY_W);
               div_in   = DW'(job_tick);
               rem_in   = '0;
               quo_in   = '0;
               iter_in  = ITER_W'(DUTY_W);
               state_in = ST_DUTY;
            end
         end
         ST_DUTY: begin
            rem_in  = step_rem;
            quo_in  = step_quo;
            num_in  = num_ff << 1;
            iter_in = iter_ff - 1'b1;
            if (iter_ff == ITER_W'(1)) begin
               duty_in  = (step_quo > DW'(pdc_pkg::DUTY_MAX)) ? pdc_pkg::DUTY_MAX
                                                             : step_quo[6:0];
               num_in   = DW'(cfg.clock_hz) << (DW - FREQ_W);
               div_in   = DW'(tick_ff) << pdc_pkg::prescale_shift(cfg.prescale_select);
               rem_in   = '0;
               quo_in   = '0;
               iter_in  = ITER_W'(FREQ_W);
               state_in = ST_FREQ;
            end
         end
         ST_FREQ: begin
            rem_in  = step_rem;
            quo_in  = step_quo;
            num_in  = num_ff << 1;
            iter_in = iter_ff - 1'b1;
            if (iter_ff == ITER_W'(1)) begin
               freq_in  = step_quo[31:0];
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in = 1'b1;
               out_per_in   = per_ff;
               out_hi_in    = hi_ff;
               out_duty_in  = zero_ff ? 7'd0 : duty_ff;
               out_freq_in  = zero_ff ? 32'd0 : freq_ff;
               out_sat_in   = sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      num_ff      <= num_in;
      quo_ff      <= quo_in;
      div_ff      <= div_in;
      iter_ff     <= iter_in;
      tick_ff     <= tick_in;
      zero_ff     <= zero_in;
      per_ff      <= per_in;
      hi_ff       <= hi_in;
      sat_ff      <= sat_in;
      duty_ff     <= duty_in;
      freq_ff     <= freq_in;
      out_per_ff  <= out_per_in;
      out_hi_ff   <= out_hi_in;
      out_duty_ff <= out_duty_in;
      out_freq_ff <= out_freq_in;
      out_sat_ff  <= out_sat_in;
   end

   assign out_valid           = out_valid_ff;
   assign out_period_ticks    = out_per_ff;
   assign out_high_ticks      = out_hi_ff;
   assign out_duty_percent    = out_duty_ff;
   assign out_frequency_hz    = out_freq_ff;
   assign out_count_saturated = out_sat_ff;

endmodule

// ===== rtl/pwm_period_duty_capture_core.sv =====
// pwm input capture: period, high time, duty and frequency of a sampled pin
// one pin sample is taken per cycle while the two-entry measurement queue has room
// each measurement holds the shared divider for its duty division and then its frequency division
// a result is registered after the duty division, frequency division and store state
// reset clears the phase, counters, queue and result valid flag; prescale 1, clock 8 MHz
`include "pwm_period_duty_capture_core_macros.svh"

module pwm_period_duty_capture_core #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_pin_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_period_ticks,
   output logic [31:0] rsp_high_ticks,
   output logic [6:0]  rsp_duty_percent,
   output logic [31:0] rsp_frequency_hz,
   output logic        rsp_count_saturated,
   input  logic        csr_write_enable,
   input  logic [pdc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pdc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam int JOB_W = 2 * COUNT_WIDTH + 1;

   logic [2:0]  prescale_ff;
   logic [31:0] clock_hz_ff;
   pdc_pkg::cfg_type cfg;

   logic                   push;
   logic [COUNT_WIDTH-1:0] push_tick;
   logic [COUNT_WIDTH-1:0] push_high;
   logic                   push_sat;
   logic                   pop;
   logic [JOB_W-1:0]       pop_data;
   pdc_pkg::fifo_status_type q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= pdc_pkg::PRESCALE_SELECT_RESET;
         clock_hz_ff <= pdc_pkg::CLOCK_HZ_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            pdc_pkg::REG_PRESCALE_SELECT: prescale_ff <= csr_write_data[2:0];
            pdc_pkg::REG_CLOCK_HZ:        clock_hz_ff <= csr_write_data[31:0];
            default: ;
         endcase
      end
   end

   assign cfg.prescale_select = prescale_ff;
   assign cfg.clock_hz        = clock_hz_ff;

   pdc_front #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_level   (req_pin_level),
      .queue_full (q_status.full),
      .push       (push),
      .push_tick  (push_tick),
      .push_high  (push_high),
      .push_sat   (push_sat)
   );

   pdc_fifo #(
      .DATA_WIDTH(JOB_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_tick, push_high, push_sat}),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   pdc_back #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .job_valid           (q_status.not_empty),
      .job_pop             (pop),
      .job_tick            (pop_data[JOB_W-1:COUNT_WIDTH+1]),
      .job_high            (pop_data[COUNT_WIDTH:1]),
      .job_sat             (pop_data[0]),
      .out_valid           (rsp_valid),
      .out_ready           (rsp_ready),
      .out_period_ticks    (rsp_period_ticks),
      .out_high_ticks      (rsp_high_ticks),
      .out_duty_percent    (rsp_duty_percent),
      .out_frequency_hz    (rsp_frequency_hz),
      .out_count_saturated (rsp_count_saturated)
   );

   // a measurement is never handed to a full queue
   `PDC_ASSERT_IMPLY(a_no_queue_overflow, clock, reset, push, !q_status.full)
   // zero period gives zero duty and zero frequency
   `PDC_ASSERT_IMPLY(a_zero_period, clock, reset, rsp_valid && (rsp_period_ticks == 32'd0),
      (rsp_duty_percent == 7'd0) && (rsp_frequency_hz == 32'd0))
   // high time never exceeds the period and duty stays in range
   `PDC_ASSERT_IMPLY(a_high_in_period, clock, reset, rsp_valid,
      (rsp_high_ticks <= rsp_period_ticks) && (rsp_duty_percent <= pdc_pkg::DUTY_MAX))

endmodule
